@@ rtl/stu_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment translation unit package
// Item types, result codes, controller states and commands shared by the
// controller, the datapath and the top level.
// ----------------------------------------------------------------------------
package stu_pkg;

  localparam logic ACT_ADD   = 1'b0;
  localparam logic ACT_XLATE = 1'b1;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_BAD_ADD = 3'd2;
  localparam logic [2:0] ST_NO_SEG  = 3'd3;
  localparam logic [2:0] ST_LIMIT   = 3'd4;
  localparam logic [2:0] ST_PROT    = 3'd5;

  typedef struct packed {
    logic        action;
    logic [3:0]  segment;
    logic [15:0] offset;
    logic [2:0]  access_kind;
    logic [15:0] new_base;
    logic [15:0] new_limit;
    logic [2:0]  new_perms;
  } stu_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [16:0] physical_address;
    logic [2:0]  slot;
    logic [31:0] access_count;
    logic [31:0] fault_count;
    logic [31:0] protection_count;
  } stu_out_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DONE
  } stu_state_t;

  typedef struct packed {
    logic load;
    logic exec;
  } stu_cmd_t;

endpackage

@@ rtl/stu_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment translation unit controller
// Sequences one item at a time: capture, execute, then hold the result
// until the consumer takes it.
// ----------------------------------------------------------------------------
module stu_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output stu_pkg::stu_cmd_t cmd
);
  import stu_pkg::*;

  stu_state_t state_r;
  stu_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    out_valid = 1'b0;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
      end
      S_DONE: begin
        out_valid = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> in_stall)
    else $error("Result shown while an item is being accepted.");
  assert property (@(posedge clk) disable iff (!rst_n) cmd.exec |=> out_valid)
    else $error("Executed item did not produce a result.");
  assert property (@(posedge clk) disable iff (!rst_n)
                   (in_valid && !in_stall) |=> cmd.exec)
    else $error("Accepted item was not executed.");

endmodule

@@ rtl/stu_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment translation unit datapath
// Holds the segment table, the saturating counters, the captured item and
// the result register.
// ----------------------------------------------------------------------------
module stu_datapath #(
  parameter int ENTRIES   = 8,
  parameter int MEM_BYTES = 65536
) (
  input  logic              clk,
  input  logic              rst_n,
  input  stu_pkg::stu_cmd_t cmd,
  input  stu_pkg::stu_in_t  in_data,
  output stu_pkg::stu_out_t out_data
);
  import stu_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam logic [16:0] MEM_LIM = 17'(MEM_BYTES);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ENTRIES);

  stu_in_t  item_r;
  stu_out_t res_r;
  stu_out_t res_nxt;

  logic [15:0] base_r  [ENTRIES];
  logic [15:0] limit_r [ENTRIES];
  logic [2:0]  perms_r [ENTRIES];

  logic [CNT_W-1:0] used_cnt_r;
  logic [CNT_W-1:0] used_cnt_nxt;
  logic [31:0]      acc_cnt_r;
  logic [31:0]      acc_cnt_nxt;
  logic [31:0]      flt_cnt_r;
  logic [31:0]      flt_cnt_nxt;
  logic [31:0]      prot_cnt_r;
  logic [31:0]      prot_cnt_nxt;

  logic             do_write;
  logic [IDX_W-1:0] wr_idx;
  logic [IDX_W-1:0] rd_idx;
  logic [16:0]      add_end;
  logic             seg_present;
  logic [15:0]      rd_base;
  logic [15:0]      rd_limit;
  logic [2:0]       rd_perms;
  logic [31:0]      used_ext;

  assign wr_idx   = used_cnt_r[IDX_W-1:0];
  assign rd_idx   = item_r.segment[IDX_W-1:0];
  assign rd_base  = base_r[rd_idx];
  assign rd_limit = limit_r[rd_idx];
  assign rd_perms = perms_r[rd_idx];
  assign add_end  = 17'(item_r.new_base) + 17'(item_r.new_limit);
  assign used_ext = 32'(used_cnt_r);
  assign seg_present = (32'(item_r.segment) < used_ext);

  always_comb begin
    res_nxt      = '0;
    do_write     = 1'b0;
    used_cnt_nxt = used_cnt_r;
    acc_cnt_nxt  = acc_cnt_r;
    flt_cnt_nxt  = flt_cnt_r;
    prot_cnt_nxt = prot_cnt_r;
    if (item_r.action == ACT_ADD) begin
      if (used_cnt_r >= FULL_CNT) begin
        res_nxt.status = ST_FULL;
      end else if ((item_r.new_limit == 16'd0) || (add_end > MEM_LIM)) begin
        res_nxt.status = ST_BAD_ADD;
      end else begin
        res_nxt.status = ST_OK;
        res_nxt.slot   = used_ext[2:0];
        do_write       = 1'b1;
        used_cnt_nxt   = used_cnt_r + CNT_W'(1);
      end
    end else begin
      acc_cnt_nxt = (acc_cnt_r == '1) ? acc_cnt_r : acc_cnt_r + 32'd1;
      if (!seg_present) begin
        res_nxt.status = ST_NO_SEG;
        flt_cnt_nxt = (flt_cnt_r == '1) ? flt_cnt_r : flt_cnt_r + 32'd1;
      end else if (item_r.offset > rd_limit) begin
        res_nxt.status = ST_LIMIT;
        flt_cnt_nxt = (flt_cnt_r == '1) ? flt_cnt_r : flt_cnt_r + 32'd1;
      end else if ((rd_perms & item_r.access_kind) == 3'd0) begin
        res_nxt.status = ST_PROT;
        prot_cnt_nxt = (prot_cnt_r == '1) ? prot_cnt_r : prot_cnt_r + 32'd1;
      end else begin
        res_nxt.status           = ST_OK;
        res_nxt.physical_address = 17'(rd_base) + 17'(item_r.offset);
      end
    end
    res_nxt.access_count     = acc_cnt_nxt;
    res_nxt.fault_count      = flt_cnt_nxt;
    res_nxt.protection_count = prot_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_cnt_r <= '0;
      acc_cnt_r  <= '0;
      flt_cnt_r  <= '0;
      prot_cnt_r <= '0;
    end else if (cmd.exec) begin
      used_cnt_r <= used_cnt_nxt;
      acc_cnt_r  <= acc_cnt_nxt;
      flt_cnt_r  <= flt_cnt_nxt;
      prot_cnt_r <= prot_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
    end
    if (cmd.exec) begin
      res_r <= res_nxt;
    end
    if (cmd.exec && do_write) begin
      base_r[wr_idx]  <= item_r.new_base;
      limit_r[wr_idx] <= item_r.new_limit;
      perms_r[wr_idx] <= item_r.new_perms;
    end
  end

  assign out_data = res_r;

  assert property (@(posedge clk) disable iff (!rst_n) used_cnt_r <= FULL_CNT)
    else $error("Segment count exceeds table size.");
  assert property (@(posedge clk) disable iff (!rst_n)
                   (cmd.exec && do_write) |=> (used_cnt_r == $past(used_cnt_r) + CNT_W'(1)))
    else $error("Segment add did not advance the count.");
  assert property (@(posedge clk) disable iff (!rst_n)
                   (cmd.exec && item_r.action == ACT_ADD) |=> $stable(acc_cnt_r))
    else $error("Add item changed the access counter.");

endmodule

@@ rtl/segment_translation_unit_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment translation unit
// Base, limit and permission table with append-only adds, checked
// translation and saturating access, fault and protection counters.
// After acceptance the item passes the execute state, then the done state,
// where the result is valid; no new item is taken until it is consumed, as
// the controller runs one item at a time through capture, execute and hold.
// Reset empties the table and clears all counters in the same cycle.
// ----------------------------------------------------------------------------
module segment_translation_unit_core #(
  parameter int ENTRIES   = 8,
  parameter int MEM_BYTES = 65536
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  stu_pkg::stu_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output stu_pkg::stu_out_t out_data
);
  import stu_pkg::*;

  stu_cmd_t cmd;

  stu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  stu_datapath #(
    .ENTRIES   (ENTRIES),
    .MEM_BYTES (MEM_BYTES)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment translation unit testbench
// Drives add and translate items through the valid/stall channels, with
// phases of sender idling and receiver stalling. A scoreboard keeps its own
// copy of the segment table and counters. It predicts every result and
// checks it field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;
  import stu_pkg::*;

  localparam int TABLE_SLOTS = 8;
  localparam int ADDR_SPAN   = 65536;
  localparam int PHASE_ITEMS = 325;

  class xlate_scoreboard;
    logic [15:0] base_tbl [TABLE_SLOTS];
    logic [15:0] limit_tbl [TABLE_SLOTS];
    logic [2:0]  perm_tbl [TABLE_SLOTS];
    int unsigned used;
    logic [31:0] xlate_cnt;
    logic [31:0] fault_cnt;
    logic [31:0] prot_cnt;
    stu_out_t    expected_q[$];
    int unsigned errors;

    function new();
      foreach (base_tbl[i]) begin
        base_tbl[i]  = '0;
        limit_tbl[i] = '0;
        perm_tbl[i]  = '0;
      end
      used      = 0;
      xlate_cnt = '0;
      fault_cnt = '0;
      prot_cnt  = '0;
      errors    = 0;
    endfunction

    function logic [31:0] bump(logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function void note_request(stu_in_t it);
      stu_out_t r;
      logic [2:0] idx;
      r   = '0;
      idx = it.segment[2:0];
      if (it.action == ACT_ADD) begin
        if (used >= TABLE_SLOTS) begin
          r.status = ST_FULL;
        end else if (it.new_limit == 16'd0 ||
                     int'(it.new_base) + int'(it.new_limit) > ADDR_SPAN) begin
          r.status = ST_BAD_ADD;
        end else begin
          r.status        = ST_OK;
          r.slot          = 3'(used);
          base_tbl[used]  = it.new_base;
          limit_tbl[used] = it.new_limit;
          perm_tbl[used]  = it.new_perms;
          used++;
        end
      end else begin
        xlate_cnt = bump(xlate_cnt);
        if (int'(it.segment) >= used) begin
          r.status  = ST_NO_SEG;
          fault_cnt = bump(fault_cnt);
        end else if (it.offset > limit_tbl[idx]) begin
          r.status  = ST_LIMIT;
          fault_cnt = bump(fault_cnt);
        end else if ((perm_tbl[idx] & it.access_kind) == 3'd0) begin
          r.status = ST_PROT;
          prot_cnt = bump(prot_cnt);
        end else begin
          r.status           = ST_OK;
          r.physical_address = {1'b0, base_tbl[idx]} + {1'b0, it.offset};
        end
      end
      r.access_count     = xlate_cnt;
      r.fault_count      = fault_cnt;
      r.protection_count = prot_cnt;
      expected_q.push_back(r);
    endfunction

    function void compare_field(string fname, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, fname, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_response(stu_out_t got);
      stu_out_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %0h", $time, got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("physical_address", 32'(want.physical_address),
                    32'(got.physical_address));
      compare_field("slot", 32'(want.slot), 32'(got.slot));
      compare_field("access_count", want.access_count, got.access_count);
      compare_field("fault_count", want.fault_count, got.fault_count);
      compare_field("protection_count", want.protection_count, got.protection_count);
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  stu_in_t   in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  stu_out_t  out_data;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  xlate_scoreboard sb;

  segment_translation_unit_core #(
    .ENTRIES   (TABLE_SLOTS),
    .MEM_BYTES (ADDR_SPAN)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic stu_in_t make_add(int unsigned b, int unsigned l, int unsigned p);
    stu_in_t it;
    it           = '0;
    it.action    = ACT_ADD;
    it.new_base  = 16'(b);
    it.new_limit = 16'(l);
    it.new_perms = 3'(p);
    return it;
  endfunction

  function automatic stu_in_t make_xlate(int unsigned s, int unsigned o, int unsigned a);
    stu_in_t it;
    it             = '0;
    it.action      = ACT_XLATE;
    it.segment     = 4'(s);
    it.offset      = 16'(o);
    it.access_kind = 3'(a);
    return it;
  endfunction

  function automatic stu_in_t random_item();
    stu_in_t it;
    int unsigned pick;
    int unsigned b;
    int unsigned hi;
    int unsigned lim;
    it.action      = 1'($urandom_range(1));
    it.segment     = 4'($urandom_range(15));
    it.offset      = 16'($urandom_range(65535));
    it.access_kind = 3'($urandom_range(7));
    it.new_base    = 16'($urandom_range(65535));
    it.new_limit   = 16'($urandom_range(65535));
    it.new_perms   = 3'($urandom_range(7));
    pick = $urandom_range(99);
    if (pick < ((sb.used < TABLE_SLOTS) ? 15 : 6)) begin
      it.action = ACT_ADD;
      pick = $urandom_range(9);
      if (pick == 0) begin
        it.new_limit = 16'd0;
      end else if (pick == 1) begin
        b            = $urandom_range(65535, 2);
        it.new_base  = 16'(b);
        it.new_limit = 16'($urandom_range(65535, ADDR_SPAN + 1 - b));
      end else begin
        b  = $urandom_range(65535);
        hi = ADDR_SPAN - b;
        if (hi > 65535) begin
          hi = 65535;
        end
        it.new_base  = 16'(b);
        it.new_limit = (pick == 2) ? 16'(hi) : 16'($urandom_range(hi, 1));
      end
    end else begin
      it.action = ACT_XLATE;
      if (sb.used != 0 && $urandom_range(9) != 0) begin
        it.segment = 4'($urandom_range(sb.used - 1));
        lim  = 32'(sb.limit_tbl[it.segment[2:0]]);
        pick = $urandom_range(99);
        if (pick < 60) begin
          it.offset = 16'($urandom_range(lim));
        end else if (pick < 70) begin
          it.offset = 16'(lim);
        end else if (pick < 85 && lim < 65535) begin
          it.offset = 16'($urandom_range(65535, lim + 1));
        end
      end
    end
    return it;
  endfunction

  task automatic send_item(input stu_in_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    sb.note_request(it);
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        sb.check_response(out_data);
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin
    stu_in_t directed[$];
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed.push_back(make_xlate(0, 0, 7));
    directed.push_back(make_add(16'h0100, 0, 7));
    directed.push_back(make_add(16'hFFFF, 2, 7));
    directed.push_back(make_add(16'hF000, 16'h1000, 7));
    directed.push_back(make_add(16'h0000, 16'hFFFF, 1));
    directed.push_back(make_add(16'h1234, 16'h0100, 6));
    directed.push_back(make_add(16'h8000, 16'h0010, 0));
    directed.push_back(make_xlate(0, 16'h1000, 4));
    directed.push_back(make_xlate(0, 16'h1001, 7));
    directed.push_back(make_xlate(0, 0, 0));
    directed.push_back(make_xlate(1, 16'hFFFF, 1));
    directed.push_back(make_xlate(1, 5, 6));
    directed.push_back(make_xlate(2, 16'h0100, 2));
    directed.push_back(make_xlate(2, 16'h0101, 2));
    directed.push_back(make_xlate(3, 0, 7));
    directed.push_back(make_xlate(4, 0, 7));
    directed.push_back(make_xlate(8, 16'hFFFF, 7));
    directed.push_back(make_xlate(15, 0, 7));
    foreach (directed[i]) begin
      send_item(directed[i]);
    end

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        send_item(random_item());
      end
    end
    in_valid <= 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;

    while (sb.expected_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
